// ===== rtl/tppd_pkg.sv =====
// Package for the touch pad press detector: shared constants, field widths
// and configuration register indexes.
// No dependencies; compile first.
package tppd_pkg;

  // Width of every sample/count field on the ports
  localparam int FIELD_W = 16;

  // Calibration collection and trimmed mean
  localparam int CAL_DEPTH   = 10;
  localparam int CAL_IDX_W   = $clog2(CAL_DEPTH);
  localparam int CAL_KEEP_LO = 2;
  localparam int CAL_KEEP_N  = 6;

  // Scan bursts and touch lockout
  localparam int BURST_SHORT = 3;
  localparam int BURST_LONG  = 6;
  localparam int BURST_W     = $clog2(BURST_LONG + 1);
  localparam int LOCK_RELOAD = 3;
  localparam int LOCK_W      = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = FIELD_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CONT_MODE = 2'd0,
    CFG_GATE      = 2'd1,
    CFG_CNT_MAX   = 2'd2
  } cfg_idx_t;

  // Item kinds, shared by request and result
  localparam logic KIND_CALIB = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

endpackage

// ===== rtl/tppd_if.sv =====
// Channel interfaces for the touch pad press detector: sample input and
// result output, each with valid/ready and payload. Depends on tppd_pkg.

interface tppd_in_if import tppd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FIELD_W-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface tppd_out_if import tppd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic               pressed;
  logic [FIELD_W-1:0] baseline_value;
  logic               calib_error;
  logic [FIELD_W-1:0] burst_peak;

  modport source (output valid, output result_kind, output pressed,
                  output baseline_value, output calib_error, output burst_peak,
                  input ready);
  modport sink   (input valid, input result_kind, input pressed,
                  input baseline_value, input calib_error, input burst_peak,
                  output ready);
endinterface

// ===== rtl/touch_pad_press_detector.sv =====
// Touch pad press detector (RC charge-time capacitive key).
// Channels: in_if carries one charge-time sample per transaction, tagged as
// calibration or scan; out_if carries at most one result per transaction;
// cfg_* is a plain write port (continuous mode, gate threshold, counter max).
// Scan samples: a sample that does not end a burst is done in its accept
// step; one that ends a burst goes on from the burst update to the touch
// decision with one add and compare. Calibration samples are done in their
// accept step, except the tenth: it starts a selection sort of the ten stored
// samples through one compare unit on a single-write memory, then a six-entry
// accumulate, a divide by six as one reciprocal multiply and the result step.
// in_if.ready is high only while the sequencer is idle; one item is in work at
// a time. A finished result sits in the output register until taken; while it
// waits the block still takes items, but a new result holds the sequencer in
// its last step until the output register is free.
// Reset (rst_n low, synchronous) clears all counters, the baseline, the
// lockout and the output valid, and loads the configuration defaults. Stored
// calibration samples are not cleared; each is written before it is read.
module touch_pad_press_detector
  import tppd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tppd_in_if.sink               in_if,
  tppd_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Effective sample width: the port field is never wider than FIELD_W
  localparam int SW     = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int SUM_W  = SW + 3;
  localparam int CMP_W  = FIELD_W + 1;
  // Reciprocal of six, exact for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + 3;
  localparam int RECIP_W   = DIV_SHIFT - 2;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam logic [CAL_IDX_W-1:0] IDX_LAST   = CAL_IDX_W'(CAL_DEPTH - 1);
  localparam logic [CAL_IDX_W-1:0] IDX_PENULT = CAL_IDX_W'(CAL_DEPTH - 2);
  localparam logic [CAL_IDX_W-1:0] IDX_KEEP0  = CAL_IDX_W'(CAL_KEEP_LO);
  localparam logic [CAL_IDX_W-1:0] IDX_KEEPZ  = CAL_IDX_W'(CAL_KEEP_LO + CAL_KEEP_N - 1);
  localparam logic [CAL_IDX_W-1:0] IDX_ONE    = CAL_IDX_W'(1);
  localparam logic [RECIP_W-1:0]   RECIP      =
    RECIP_W'(((1 << DIV_SHIFT) + CAL_KEEP_N - 1) / CAL_KEEP_N);
  localparam logic [BURST_W-1:0]   LEN_SHORT  = BURST_W'(BURST_SHORT);
  localparam logic [BURST_W-1:0]   LEN_LONG   = BURST_W'(BURST_LONG);
  localparam logic [LOCK_W-1:0]    LOCK_FULL  = LOCK_W'(LOCK_RELOAD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GETA,
    S_CMP,
    S_PUT,
    S_ACC,
    S_DIV,
    S_CAL_OUT,
    S_DECIDE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CAL_IDX_W-1:0] i_r, i_nxt;
  logic [CAL_IDX_W-1:0] j_r, j_nxt;
  logic [SW-1:0]        a_r, a_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CAL_IDX_W-1:0] calib_cnt_r, calib_cnt_nxt;
  logic [SW-1:0]        baseline_r, baseline_nxt;
  logic [BURST_W-1:0]   burst_cnt_r, burst_cnt_nxt;
  logic [SW-1:0]        burst_max_r, burst_max_nxt;
  logic [LOCK_W-1:0]    lockout_r, lockout_nxt;
  logic                 cont_mode_r, cont_mode_nxt;
  logic [FIELD_W-1:0]   gate_r, gate_nxt;
  logic [FIELD_W-1:0]   cnt_max_r, cnt_max_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic                 out_pressed_r, out_pressed_nxt;
  logic [FIELD_W-1:0]   out_base_r, out_base_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [FIELD_W-1:0]   out_peak_r, out_peak_nxt;

  // Calibration sample store
  logic [SW-1:0]        cal_mem [CAL_DEPTH];
  logic [SW-1:0]        rdata_r;
  logic                 mem_we;
  logic [CAL_IDX_W-1:0] mem_waddr;
  logic [SW-1:0]        mem_wdata;
  logic [CAL_IDX_W-1:0] mem_raddr;

  // Datapath helpers
  logic                 in_fire;
  logic                 out_busy;
  logic [SW-1:0]        s_eff;
  logic [SW-1:0]        new_max;
  logic [BURST_W-1:0]   cnt_inc;
  logic [BURST_W-1:0]   burst_len;
  logic [PROD_W-1:0]    div_prod;
  logic [SW-1:0]        div_q;
  logic [CMP_W-1:0]     thresh;
  logic                 hit;
  logic [LOCK_W-1:0]    lock_pre;
  logic [LOCK_W-1:0]    lock_hit;
  logic [SW-1:0]        quot;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_busy    = out_valid_r && !out_if.ready;
  assign s_eff       = in_if.sample[SW-1:0];

  // Compare unit for burst peak tracking
  assign new_max   = ((burst_cnt_r == '0) || (s_eff > burst_max_r)) ? s_eff : burst_max_r;
  assign cnt_inc   = burst_cnt_r + BURST_W'(1);
  assign burst_len = cont_mode_r ? LEN_LONG : LEN_SHORT;

  // Divide the middle sum by six with one reciprocal multiply
  assign div_prod = PROD_W'(sum_r) * PROD_W'(RECIP);
  assign div_q    = div_prod[DIV_SHIFT +: SW];
  assign quot     = sum_r[SW-1:0];

  // Touch decision: compare at one bit over field width, no wrap
  assign thresh   = CMP_W'(baseline_r) + CMP_W'(gate_r);
  assign hit      = CMP_W'(burst_max_r) > thresh;
  assign lock_pre = cont_mode_r ? '0 : lockout_r;
  assign lock_hit = hit ? LOCK_FULL : lock_pre;

  // Next-state and datapath control
  always_comb begin
    state_nxt       = state_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    a_nxt           = a_r;
    sum_nxt         = sum_r;
    calib_cnt_nxt   = calib_cnt_r;
    baseline_nxt    = baseline_r;
    burst_cnt_nxt   = burst_cnt_r;
    burst_max_nxt   = burst_max_r;
    lockout_nxt     = lockout_r;
    cont_mode_nxt   = cont_mode_r;
    gate_nxt        = gate_r;
    cnt_max_nxt     = cnt_max_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_pressed_nxt = out_pressed_r;
    out_base_nxt    = out_base_r;
    out_err_nxt     = out_err_r;
    out_peak_nxt    = out_peak_r;
    mem_we          = 1'b0;
    mem_waddr       = calib_cnt_r;
    mem_wdata       = s_eff;
    mem_raddr       = j_r;

    // Drop the result once taken
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes; unknown indexes are ignored
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CONT_MODE: cont_mode_nxt = cfg_wdata[0];
        CFG_GATE:      gate_nxt      = cfg_wdata;
        CFG_CNT_MAX:   cnt_max_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_if.req_type == KIND_CALIB) begin
            // Store the sample; the tenth one starts the sort
            mem_we = 1'b1;
            if (calib_cnt_r == IDX_LAST) begin
              calib_cnt_nxt = '0;
              i_nxt         = '0;
              mem_raddr     = '0;
              state_nxt     = S_GETA;
            end else begin
              calib_cnt_nxt = calib_cnt_r + IDX_ONE;
            end
          end else begin
            // Track the burst peak; a full burst goes to the decision
            burst_max_nxt = new_max;
            if (cnt_inc >= burst_len) begin
              burst_cnt_nxt = '0;
              state_nxt     = S_DECIDE;
            end else begin
              burst_cnt_nxt = cnt_inc;
            end
          end
        end
      end

      S_GETA: begin
        // Hold entry i as the running minimum, fetch i+1
        a_nxt     = rdata_r;
        j_nxt     = i_r + IDX_ONE;
        mem_raddr = i_r + IDX_ONE;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        // Swap when the held value is larger than entry j
        if (a_r > rdata_r) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = a_r;
          a_nxt     = rdata_r;
        end
        if (j_r == IDX_LAST) begin
          state_nxt = S_PUT;
        end else begin
          j_nxt     = j_r + IDX_ONE;
          mem_raddr = j_r + IDX_ONE;
        end
      end

      S_PUT: begin
        // Settle position i, then next pass or start the middle sum
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = a_r;
        if (i_r == IDX_PENULT) begin
          j_nxt     = IDX_KEEP0;
          mem_raddr = IDX_KEEP0;
          sum_nxt   = '0;
          state_nxt = S_ACC;
        end else begin
          i_nxt     = i_r + IDX_ONE;
          mem_raddr = i_r + IDX_ONE;
          state_nxt = S_GETA;
        end
      end

      S_ACC: begin
        // Sum the six middle entries at full width
        sum_nxt = sum_r + SUM_W'(rdata_r);
        if (j_r == IDX_KEEPZ) begin
          state_nxt = S_DIV;
        end else begin
          j_nxt     = j_r + IDX_ONE;
          mem_raddr = j_r + IDX_ONE;
        end
      end

      S_DIV: begin
        // Replace the sum by its quotient
        sum_nxt   = SUM_W'(div_q);
        state_nxt = S_CAL_OUT;
      end

      S_CAL_OUT: begin
        // Publish the new baseline once the output register is free
        if (!out_busy) begin
          baseline_nxt    = quot;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_CALIB;
          out_pressed_nxt = 1'b0;
          out_base_nxt    = FIELD_W'(quot);
          out_err_nxt     = FIELD_W'(quot) > (cnt_max_r >> 1);
          out_peak_nxt    = '0;
          state_nxt       = S_IDLE;
        end
      end

      S_DECIDE: begin
        // Report a touch only out of lockout, then advance the lockout
        if (!out_busy) begin
          lockout_nxt     = (lock_hit != '0) ? lock_hit - LOCK_W'(1) : '0;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_SCAN;
          out_pressed_nxt = hit && (lock_pre == '0);
          out_base_nxt    = FIELD_W'(baseline_r);
          out_err_nxt     = 1'b0;
          out_peak_nxt    = FIELD_W'(burst_max_r);
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, counters, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      calib_cnt_r <= '0;
      baseline_r  <= '0;
      burst_cnt_r <= '0;
      burst_max_r <= '0;
      lockout_r   <= '0;
      cont_mode_r <= 1'b0;
      gate_r      <= FIELD_W'(100);
      cnt_max_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      calib_cnt_r <= calib_cnt_nxt;
      baseline_r  <= baseline_nxt;
      burst_cnt_r <= burst_cnt_nxt;
      burst_max_r <= burst_max_nxt;
      lockout_r   <= lockout_nxt;
      cont_mode_r <= cont_mode_nxt;
      gate_r      <= gate_nxt;
      cnt_max_r   <= cnt_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    a_r           <= a_nxt;
    sum_r         <= sum_nxt;
    out_kind_r    <= out_kind_nxt;
    out_pressed_r <= out_pressed_nxt;
    out_base_r    <= out_base_nxt;
    out_err_r     <= out_err_nxt;
    out_peak_r    <= out_peak_nxt;
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cal_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= cal_mem[mem_raddr];
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.result_kind    = out_kind_r;
  assign out_if.pressed        = out_pressed_r;
  assign out_if.baseline_value = out_base_r;
  assign out_if.calib_error    = out_err_r;
  assign out_if.burst_peak     = out_peak_r;

endmodule

// ===== rtl/tppd_checker.sv =====
// Port-level checks for the touch pad press detector, attached by bind.
// Depends on tppd_pkg and the top level touch_pad_press_detector.
module tppd_checker
  import tppd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_result_kind,
  input logic               out_pressed,
  input logic               out_calib_error,
  input logic [FIELD_W-1:0] out_burst_peak
);

  // Hold a result until the transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // Calibration results carry no touch and no peak
  a_calib_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_CALIB) |-> !out_pressed && (out_burst_peak == '0))
    else $error("calibration result carries scan fields");

  // Scan results never flag a calibration error
  a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_SCAN) |-> !out_calib_error)
    else $error("scan result flags calibration error");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind touch_pad_press_detector tppd_checker u_tppd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_result_kind (out_if.result_kind),
  .out_pressed     (out_if.pressed),
  .out_calib_error (out_if.calib_error),
  .out_burst_peak  (out_if.burst_peak)
);
